[hw/rtl/qvr_pkg.sv]
// Shared constants for the quaternion vector rotator.
package qvr_pkg;

    // Default field widths.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF  = 16;

    // Configuration register map.
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_W   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_I   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_J   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_K   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKWARD = 3'd4;

endpackage

[hw/rtl/quaternion_vector_rotator_top.sv]
// Quaternion vector rotator: four-stage pipelined rotation of 3D vectors.
//
// Rotates one signed fixed-point vector (x, y, z) per word by the unit
// quaternion held in the configuration registers. Forward mode gives
// conj(q)*v*q, backward mode q*v*conj(q); only the vector part is returned.
// The block folds the mode into an operand set p = q (forward) or conj(q)
// (backward), so both modes run as t = v*p then r = conj(p)*t. An accepted
// word moves through the registers of stages 1, 2, 3 and 4 in order, and
// output valid is the stage 4 valid bit. One vector enters every cycle
// while the output is not stalled: each of the two Hamilton products owns a
// bank of twelve multipliers (stage 1 and stage 3), and their rounded sums
// sit in stages 2 and 4, so nothing is shared between items. Each stage has
// its own valid bit and ready term, so bubbles close up and a stalled output does
// not block input while a stage is free. Products round to nearest (ties toward
// plus infinity) and the outputs saturate to the coordinate width. Configuration
// must be written only while the pipe is empty; the block does not enforce this.
// Writes to indexes beyond the register list are ignored.
module quaternion_vector_rotator_top #(
    parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qvr_pkg::QUAT_WIDTH_DEF,
    localparam int TDATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [qvr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [QUAT_WIDTH-1:0]         i_cfg_wdata,

    // input vector stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [TDATA_W-1:0]            i_s_tdata,  // vec_x, vec_y, vec_z (low first)

    // rotated vector stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [TDATA_W-1:0]            o_m_tdata   // rot_x, rot_y, rot_z (low first)
);

    // ---- widths ----
    localparam int CW   = COORD_WIDTH;
    localparam int FB   = QUAT_WIDTH - 2;      // quaternion fraction bits
    localparam int PW   = QUAT_WIDTH + 1;      // p operand, holds -(-2.0)
    localparam int P1W  = CW + PW;             // v x p product
    localparam int S1W  = P1W + 2;             // three terms plus round
    localparam int TW   = CW + 3;              // intermediate t
    localparam int P2W  = TW + PW;             // t x p product
    localparam int S2W  = P2W + 3;             // four terms plus round
    localparam int RW   = S2W - FB;            // rounded result before sat

    localparam logic signed [S1W-1:0] RND1 = S1W'(1) <<< (FB - 1);
    localparam logic signed [S2W-1:0] RND2 = S2W'(1) <<< (FB - 1);
    localparam logic [QUAT_WIDTH-1:0] QW_RESET = QUAT_WIDTH'(1) << FB;

    // ---- configuration ----
    logic [QUAT_WIDTH-1:0] r_qw, r_qi, r_qj, r_qk;
    logic [QUAT_WIDTH-1:0] n_qw, n_qi, n_qj, n_qk;
    logic                  r_bwd, n_bwd;
    // p = q or conj(q), kept in step with the raw registers
    logic signed [PW-1:0]  r_pw, r_pa, r_pb, r_pc;

    always_comb begin
        n_qw  = r_qw;
        n_qi  = r_qi;
        n_qj  = r_qj;
        n_qk  = r_qk;
        n_bwd = r_bwd;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                qvr_pkg::REG_QUAT_W:   n_qw  = i_cfg_wdata;
                qvr_pkg::REG_QUAT_I:   n_qi  = i_cfg_wdata;
                qvr_pkg::REG_QUAT_J:   n_qj  = i_cfg_wdata;
                qvr_pkg::REG_QUAT_K:   n_qk  = i_cfg_wdata;
                qvr_pkg::REG_BACKWARD: n_bwd = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw  <= QW_RESET;
            r_qi  <= '0;
            r_qj  <= '0;
            r_qk  <= '0;
            r_bwd <= 1'b0;
            r_pw  <= PW'($signed(QW_RESET));
            r_pa  <= '0;
            r_pb  <= '0;
            r_pc  <= '0;
        end else begin
            r_qw  <= n_qw;
            r_qi  <= n_qi;
            r_qj  <= n_qj;
            r_qk  <= n_qk;
            r_bwd <= n_bwd;
            r_pw  <= PW'($signed(n_qw));
            r_pa  <= n_bwd ? -PW'($signed(n_qi)) : PW'($signed(n_qi));
            r_pb  <= n_bwd ? -PW'($signed(n_qj)) : PW'($signed(n_qj));
            r_pc  <= n_bwd ? -PW'($signed(n_qk)) : PW'($signed(n_qk));
        end
    end

    // ---- handshake: per-stage ready so bubbles collapse ----
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || i_m_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_s_tready = rdy1;
    assign o_m_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: v x p products ----
    logic signed [CW-1:0]  vx, vy, vz;
    logic signed [P1W-1:0] r_m1 [12];

    assign vx = $signed(i_s_tdata[CW-1:0]);
    assign vy = $signed(i_s_tdata[2*CW-1:CW]);
    assign vz = $signed(i_s_tdata[3*CW-1:2*CW]);

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_tvalid) begin
            // t0 terms
            r_m1[0]  <= P1W'(vx) * P1W'(r_pa);
            r_m1[1]  <= P1W'(vy) * P1W'(r_pb);
            r_m1[2]  <= P1W'(vz) * P1W'(r_pc);
            // t1 terms
            r_m1[3]  <= P1W'(vx) * P1W'(r_pw);
            r_m1[4]  <= P1W'(vy) * P1W'(r_pc);
            r_m1[5]  <= P1W'(vz) * P1W'(r_pb);
            // t2 terms
            r_m1[6]  <= P1W'(vx) * P1W'(r_pc);
            r_m1[7]  <= P1W'(vy) * P1W'(r_pw);
            r_m1[8]  <= P1W'(vz) * P1W'(r_pa);
            // t3 terms
            r_m1[9]  <= P1W'(vx) * P1W'(r_pb);
            r_m1[10] <= P1W'(vy) * P1W'(r_pa);
            r_m1[11] <= P1W'(vz) * P1W'(r_pw);
        end
    end

    // ---- stage 2: sum, round, t = v*p ----
    logic signed [S1W-1:0] s1 [4];
    logic signed [S1W-1:0] s1_sh [4];
    logic signed [TW-1:0]  r_t [4];

    always_comb begin
        s1[0] = RND1 - S1W'(r_m1[0]) - S1W'(r_m1[1])  - S1W'(r_m1[2]);
        s1[1] = RND1 + S1W'(r_m1[3]) + S1W'(r_m1[4])  - S1W'(r_m1[5]);
        s1[2] = RND1 - S1W'(r_m1[6]) + S1W'(r_m1[7])  + S1W'(r_m1[8]);
        s1[3] = RND1 + S1W'(r_m1[9]) - S1W'(r_m1[10]) + S1W'(r_m1[11]);
        for (int n = 0; n < 4; n++) begin
            s1_sh[n] = s1[n] >>> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            for (int n = 0; n < 4; n++) begin
                r_t[n] <= s1_sh[n][TW-1:0];
            end
        end
    end

    // ---- stage 3: conj(p) x t products ----
    logic signed [P2W-1:0] r_m2 [12];

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            // r1: w t1, a t0, b t3, c t2
            r_m2[0]  <= P2W'(r_pw) * P2W'(r_t[1]);
            r_m2[1]  <= P2W'(r_pa) * P2W'(r_t[0]);
            r_m2[2]  <= P2W'(r_pb) * P2W'(r_t[3]);
            r_m2[3]  <= P2W'(r_pc) * P2W'(r_t[2]);
            // r2: w t2, a t3, b t0, c t1
            r_m2[4]  <= P2W'(r_pw) * P2W'(r_t[2]);
            r_m2[5]  <= P2W'(r_pa) * P2W'(r_t[3]);
            r_m2[6]  <= P2W'(r_pb) * P2W'(r_t[0]);
            r_m2[7]  <= P2W'(r_pc) * P2W'(r_t[1]);
            // r3: w t3, a t2, b t1, c t0
            r_m2[8]  <= P2W'(r_pw) * P2W'(r_t[3]);
            r_m2[9]  <= P2W'(r_pa) * P2W'(r_t[2]);
            r_m2[10] <= P2W'(r_pb) * P2W'(r_t[1]);
            r_m2[11] <= P2W'(r_pc) * P2W'(r_t[0]);
        end
    end

    // ---- stage 4: sum, round, saturate ----
    logic signed [S2W-1:0] s2 [3];
    logic signed [S2W-1:0] s2_sh [3];
    logic        [CW-1:0]  sat [3];
    logic        [CW-1:0]  r_rot [3];

    always_comb begin
        s2[0] = RND2 + S2W'(r_m2[0]) - S2W'(r_m2[1]) - S2W'(r_m2[2])  + S2W'(r_m2[3]);
        s2[1] = RND2 + S2W'(r_m2[4]) + S2W'(r_m2[5]) - S2W'(r_m2[6])  - S2W'(r_m2[7]);
        s2[2] = RND2 + S2W'(r_m2[8]) - S2W'(r_m2[9]) + S2W'(r_m2[10]) - S2W'(r_m2[11]);
        for (int n = 0; n < 3; n++) begin
            s2_sh[n] = s2[n] >>> FB;
            // in range when every bit above the result's sign matches it
            if (s2_sh[n][RW-1:CW-1] == '0 || s2_sh[n][RW-1:CW-1] == '1) begin
                sat[n] = s2_sh[n][CW-1:0];
            end else begin
                sat[n] = {s2_sh[n][RW-1], {(CW-1){~s2_sh[n][RW-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            for (int n = 0; n < 3; n++) begin
                r_rot[n] <= sat[n];
            end
        end
    end

    assign o_m_tdata = TDATA_W'({r_rot[2], r_rot[1], r_rot[0]});

endmodule
